[rtl/frq_pkg.sv]
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and constants of the floor request queue.
// ----------------------------------------------------------------------------
`default_nettype none

package frq_pkg;

  localparam int FLOOR_W = 2;
  localparam int TYPE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int OCC_W   = 5;
  localparam int LIM_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_POP    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  localparam logic [TYPE_W-1:0] TYPE_UP   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_DOWN = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_CAB  = 2'd2;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic [TYPE_W-1:0]  order_type;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic [FLOOR_W-1:0] floor;
    logic [TYPE_W-1:0]  order_type;
    logic               direction;
  } query_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

[rtl/frq_in_if.sv]
// ----------------------------------------------------------------------------
// frq_in_if
// Request channel: one queue operation per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface frq_in_if;
  logic                       valid;
  logic                       ready;
  logic [frq_pkg::KIND_W-1:0]  kind;
  logic [frq_pkg::FLOOR_W-1:0] floor;
  logic [frq_pkg::TYPE_W-1:0]  order_type;
  logic                       direction;

  modport source (output valid, kind, floor, order_type, direction, input ready);
  modport sink   (input valid, kind, floor, order_type, direction, output ready);
endinterface

`default_nettype wire

[rtl/frq_out_if.sv]
// ----------------------------------------------------------------------------
// frq_out_if
// Result channel: one item per operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface frq_out_if;
  logic                       valid;
  logic                       ready;
  logic                       done_res;
  logic [frq_pkg::FLOOR_W-1:0] popped_floor;
  logic [frq_pkg::TYPE_W-1:0]  popped_type;
  logic                       should_stop;
  logic [frq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, done_res, popped_floor, popped_type, should_stop,
                  occupancy, input ready);
  modport sink   (input valid, done_res, popped_floor, popped_type, should_stop,
                  occupancy, output ready);
endinterface

`default_nettype wire

[rtl/frq_store.sv]
// ----------------------------------------------------------------------------
// frq_store
// Order storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module frq_store #(
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [$clog2(DEPTH)-1:0]  wr_addr,
  input  frq_pkg::entry_t          wr_data,
  input  wire [$clog2(DEPTH)-1:0]  rd_addr,
  output frq_pkg::entry_t          rd_data
);

  frq_pkg::entry_t mem [DEPTH];
  frq_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/frq_match.sv]
// ----------------------------------------------------------------------------
// frq_match
// Shared entry compare unit for pop, remove and stop check.
// ----------------------------------------------------------------------------
`default_nettype none

module frq_match (
  input  frq_pkg::query_t query,
  input  frq_pkg::entry_t entry,
  output logic            hit
);

  logic floor_eq;
  logic serves;

  assign floor_eq = (entry.floor == query.floor);

  always_comb begin
    serves = (entry.order_type == frq_pkg::TYPE_CAB) ||
             ((entry.order_type == frq_pkg::TYPE_UP) && (query.direction == frq_pkg::DIR_UP)) ||
             ((entry.order_type == frq_pkg::TYPE_DOWN) &&
              (query.direction == frq_pkg::DIR_DOWN));
    case (query.kind)
      frq_pkg::KIND_POP:    hit = 1'b1;
      frq_pkg::KIND_REMOVE: hit = floor_eq && (entry.order_type == query.order_type);
      frq_pkg::KIND_STOP:   hit = floor_eq && serves;
      default:              hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/floor_request_queue.sv]
// ----------------------------------------------------------------------------
// floor_request_queue
// Bounded queue of elevator orders with pop, match-remove and stop check.
// ----------------------------------------------------------------------------
// One item at a time, walked by a small sequencer over an order store with
// one write port and one registered read port, and one shared compare unit.
// An add is accepted and then answered. A pop, remove or stop check scans
// entries oldest first, reading and then comparing each entry; on a hit,
// pop and remove then close the gap by reading and writing back each later
// entry in turn, and then drop the count. A stop check ends at its first
// hit, and a search without a hit ends after the last entry. On an empty
// queue a pop, remove or stop check skips the scan.
// in_ch.ready is high only while idle; a result waits in the output register
// until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module floor_request_queue #(
  parameter int DEPTH      = 16,
  parameter int NUM_FLOORS = 4
) (
  input  wire                         clk,
  input  wire                         rst_n,
  frq_in_if.sink                      in_ch,
  frq_out_if.source                   out_ch,
  input  wire                         cfg_we,
  input  wire [frq_pkg::LIM_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = (CNT_W > frq_pkg::LIM_W) ? CNT_W : frq_pkg::LIM_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  frq_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [frq_pkg::LIM_W-1:0]  limit_r;
  frq_pkg::query_t            op_r, op_nxt;
  logic                       done_r, done_nxt;
  logic                       stop_r, stop_nxt;
  logic [frq_pkg::FLOOR_W-1:0] pf_r, pf_nxt;
  logic [frq_pkg::TYPE_W-1:0]  pt_r, pt_nxt;

  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  frq_pkg::entry_t            wr_data;
  logic [IDX_W-1:0]           rd_addr;
  frq_pkg::entry_t            rd_data;
  logic                       hit;

  logic [CNT_W-1:0]           idx_plus;
  logic [IDX_W-1:0]           idx_inc;
  logic                       last;
  logic                       full;
  logic                       add_ok;
  logic [LW-1:0]              cnt_ext;
  logic [LW-1:0]              occ_ext;

  frq_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  frq_match u_match (
    .query (op_r),
    .entry (rd_data),
    .hit   (hit)
  );

  assign idx_plus = CNT_W'(idx_r) + CNT_W'(1);
  assign idx_inc  = idx_plus[IDX_W-1:0];
  assign last     = (idx_plus >= cnt_r);
  assign cnt_ext  = LW'(cnt_r);
  assign full     = (cnt_r >= DEPTH_C) ||
                    ((limit_r != '0) && (cnt_ext >= LW'(limit_r)));
  assign add_ok   = !full && (in_ch.order_type <= frq_pkg::TYPE_CAB) &&
                    (32'(in_ch.floor) < 32'(NUM_FLOORS));
  assign occ_ext  = LW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frq_pkg::ST_IDLE;
      cnt_r   <= '0;
      limit_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    op_r   <= op_nxt;
    done_r <= done_nxt;
    stop_r <= stop_nxt;
    pf_r   <= pf_nxt;
    pt_r   <= pt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    done_nxt  = done_r;
    stop_nxt  = stop_r;
    pf_nxt    = pf_r;
    pt_nxt    = pt_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data;
    rd_addr   = idx_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      frq_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt.kind       = frq_pkg::kind_t'(in_ch.kind);
          op_nxt.floor      = in_ch.floor;
          op_nxt.order_type = in_ch.order_type;
          op_nxt.direction  = in_ch.direction;
          done_nxt = 1'b0;
          stop_nxt = 1'b0;
          pf_nxt   = '0;
          pt_nxt   = '0;
          idx_nxt  = '0;
          if (frq_pkg::kind_t'(in_ch.kind) == frq_pkg::KIND_ADD) begin
            if (add_ok) begin
              wr_en   = 1'b1;
              wr_addr = cnt_r[IDX_W-1:0];
              wr_data.floor      = in_ch.floor;
              wr_data.order_type = in_ch.order_type;
              cnt_nxt  = cnt_r + CNT_W'(1);
              done_nxt = 1'b1;
            end
            state_nxt = frq_pkg::ST_RESP;
          end else if (cnt_r == '0) begin
            state_nxt = frq_pkg::ST_RESP;
          end else begin
            state_nxt = frq_pkg::ST_RD;
          end
        end
      end
      frq_pkg::ST_RD: begin
        rd_addr   = idx_r;
        state_nxt = frq_pkg::ST_CMP;
      end
      frq_pkg::ST_CMP: begin
        if (hit) begin
          if (op_r.kind == frq_pkg::KIND_STOP) begin
            stop_nxt  = 1'b1;
            state_nxt = frq_pkg::ST_RESP;
          end else begin
            done_nxt = 1'b1;
            if (op_r.kind == frq_pkg::KIND_POP) begin
              pf_nxt = rd_data.floor;
              pt_nxt = rd_data.order_type;
            end
            state_nxt = frq_pkg::ST_SH_RD;
          end
        end else if (last) begin
          state_nxt = frq_pkg::ST_RESP;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = frq_pkg::ST_RD;
        end
      end
      frq_pkg::ST_SH_RD: begin
        if (last) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = frq_pkg::ST_RESP;
        end else begin
          rd_addr   = idx_inc;
          state_nxt = frq_pkg::ST_SH_WR;
        end
      end
      frq_pkg::ST_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = rd_data;
        idx_nxt   = idx_inc;
        state_nxt = frq_pkg::ST_SH_RD;
      end
      frq_pkg::ST_RESP: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = frq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = frq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_ch.done_res     = done_r;
  assign out_ch.popped_floor = pf_r;
  assign out_ch.popped_type  = pt_r;
  assign out_ch.should_stop  = stop_r;
  assign out_ch.occupancy    = occ_ext[frq_pkg::OCC_W-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above depth");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  a_scan_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == frq_pkg::ST_IDLE && in_ch.valid &&
     frq_pkg::kind_t'(in_ch.kind) != frq_pkg::KIND_ADD) |=> $stable(cnt_r))
    else $error("count changed at start of a scan");

  a_stop_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.should_stop) |-> !out_ch.done_res)
    else $error("stop check reported done");

endmodule

`default_nettype wire

[test/tb_floor_request_queue.sv]
// ----------------------------------------------------------------------------
// tb_floor_request_queue
// Self-checking bench for the floor request queue. A driver feeds queue
// operations from a pending list, a monitor checks every result against a
// behavioral queue of stored orders, and the limit register is changed
// between phases while the block is idle. Directed cases cover the empty,
// full, invalid-type and no-match paths; random phases follow.
// ----------------------------------------------------------------------------
module tb_floor_request_queue;
  import frq_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int FLOORS      = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4 * QDEPTH + 16;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 137;

  typedef struct packed {
    logic               done_res;
    logic [FLOOR_W-1:0] popped_floor;
    logic [TYPE_W-1:0]  popped_type;
    logic               should_stop;
    logic [OCC_W-1:0]   occupancy;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LIM_W-1:0] cfg_data;

  frq_in_if  in_ch ();
  frq_out_if out_ch ();

  floor_request_queue #(
    .DEPTH      (QDEPTH),
    .NUM_FLOORS (FLOORS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  query_t           ops_pending[$];
  outcome_t         outcomes_due[$];
  entry_t           orders_held[$];
  logic [LIM_W-1:0] limit_q = '0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               errors = 0;
  int               stall_cycles = 0;

  function automatic outcome_t apply_op(query_t op);
    outcome_t res;
    int       cap;
    res = '0;
    cap = (limit_q == 0 || limit_q > QDEPTH) ? QDEPTH : int'(limit_q);
    case (op.kind)
      KIND_ADD: begin
        if (orders_held.size() < cap && op.order_type <= TYPE_CAB && op.floor < FLOORS) begin
          orders_held.push_back('{floor: op.floor, order_type: op.order_type});
          res.done_res = 1'b1;
        end
      end
      KIND_POP: begin
        if (orders_held.size() != 0) begin
          res.popped_floor = orders_held[0].floor;
          res.popped_type  = orders_held[0].order_type;
          void'(orders_held.pop_front());
          res.done_res = 1'b1;
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < orders_held.size(); i++) begin
          if (orders_held[i].floor == op.floor && orders_held[i].order_type == op.order_type) begin
            orders_held.delete(i);
            res.done_res = 1'b1;
            break;
          end
        end
      end
      default: begin
        foreach (orders_held[i]) begin
          if (orders_held[i].floor == op.floor &&
              (orders_held[i].order_type == TYPE_CAB ||
               (orders_held[i].order_type == TYPE_UP && op.direction == DIR_UP) ||
               (orders_held[i].order_type == TYPE_DOWN && op.direction == DIR_DOWN)))
            res.should_stop = 1'b1;
        end
      end
    endcase
    res.occupancy = OCC_W'(orders_held.size());
    return res;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic queue_op(input kind_t k, input int fl, input int ty, input int dir);
    query_t op;
    op.kind       = k;
    op.floor      = FLOOR_W'(fl);
    op.order_type = TYPE_W'(ty);
    op.direction  = 1'(dir);
    ops_pending.push_back(op);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    limit_q = value;
  endtask

  task automatic settle();
    while (ops_pending.size() != 0 || outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : request_driver
    logic taken;
    taken = in_ch.valid && in_ch.ready;
    if (taken) outcomes_due.push_back(apply_op(ops_pending.pop_front()));
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || taken) begin
      if (ops_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= ops_pending[0].kind;
        in_ch.floor      <= ops_pending[0].floor;
        in_ch.order_type <= ops_pending[0].order_type;
        in_ch.direction  <= ops_pending[0].direction;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    outcome_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{done_res: out_ch.done_res, popped_floor: out_ch.popped_floor,
              popped_type: out_ch.popped_type, should_stop: out_ch.should_stop,
              occupancy: out_ch.occupancy};
      if (outcomes_due.size() == 0) begin
        flag_error($sformatf("unexpected result done=%0b occ=%0d", got.done_res,
                             got.occupancy));
      end else begin
        want = outcomes_due.pop_front();
        if (got.done_res !== want.done_res || got.popped_floor !== want.popped_floor ||
            got.popped_type !== want.popped_type || got.should_stop !== want.should_stop ||
            got.occupancy !== want.occupancy)
          flag_error($sformatf(
            "exp done=%0b pf=%0d pt=%0d stop=%0b occ=%0d, got done=%0b pf=%0d pt=%0d stop=%0b occ=%0d",
            want.done_res, want.popped_floor, want.popped_type, want.should_stop,
            want.occupancy, got.done_res, got.popped_floor, got.popped_type,
            got.should_stop, got.occupancy));
      end
    end
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [LIM_W-1:0] limits [PHASES];
    query_t           op;
    int               add_pct;
    int               r;
    limits = '{5'd16, 5'd31, 5'd1, 5'd5, 5'd0, 5'd17, 5'd3, 5'd12, 5'd16};
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = '0;
    in_ch.floor      = '0;
    in_ch.order_type = '0;
    in_ch.direction  = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, invalid type, stop directions, no-match remove
    @(negedge clk);
    send_idle_pct = 22;
    recv_idle_pct = 72;
    queue_op(KIND_POP, 0, 0, 0);
    queue_op(KIND_REMOVE, 3, TYPE_CAB, 0);
    queue_op(KIND_STOP, 0, 0, DIR_UP);
    queue_op(KIND_ADD, 0, TYPE_UP, 0);
    queue_op(KIND_ADD, 3, TYPE_CAB, 1);
    queue_op(KIND_ADD, 1, TYPE_DOWN, 0);
    queue_op(KIND_ADD, 2, 3, 0);
    queue_op(KIND_STOP, 0, 0, DIR_UP);
    queue_op(KIND_STOP, 0, 3, DIR_DOWN);
    queue_op(KIND_STOP, 3, 0, DIR_DOWN);
    queue_op(KIND_STOP, 1, 0, DIR_DOWN);
    queue_op(KIND_REMOVE, 1, 3, 0);
    settle();

    // limit lowered below the stored count, middle remove, pop to empty
    write_limit(5'd2);
    @(negedge clk);
    queue_op(KIND_ADD, 2, TYPE_UP, 0);
    queue_op(KIND_REMOVE, 3, TYPE_CAB, 0);
    queue_op(KIND_ADD, 2, TYPE_DOWN, 0);
    queue_op(KIND_POP, 0, 0, 0);
    queue_op(KIND_POP, 0, 0, 0);
    queue_op(KIND_POP, 0, 0, 0);
    queue_op(KIND_ADD, 2, TYPE_UP, 0);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_limit(limits[ph]);
      @(negedge clk);
      send_idle_pct = (ph < 3) ? 22 : (ph < 6) ? 72 : 0;
      recv_idle_pct = (ph < 3) ? 72 : (ph < 6) ? 22 : 0;
      add_pct = (ph % 2 == 0) ? 55 : 30;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < add_pct) op.kind = KIND_ADD;
        else if (r < add_pct + 15) op.kind = KIND_POP;
        else if (r < add_pct + 15 + (85 - add_pct) / 2) op.kind = KIND_REMOVE;
        else op.kind = KIND_STOP;
        op.floor      = FLOOR_W'($urandom_range(FLOORS - 1));
        op.order_type = ($urandom_range(9) == 0) ? 2'd3 : TYPE_W'($urandom_range(2));
        op.direction  = 1'($urandom_range(1));
        ops_pending.push_back(op);
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outcomes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
